// File: sv/dsf_pkg.sv
`default_nettype none

package dsf_pkg;

  // Widths fixed by the interface.
  localparam int unsigned NumWidth    = 27;
  localparam int unsigned NumPlaces   = 8;
  localparam int unsigned DigitWidth  = 4;
  localparam int unsigned BcdWidth    = NumPlaces * DigitWidth;
  localparam int unsigned ByteWidth   = 8;
  localparam int unsigned BrightWidth = 3;
  localparam int unsigned CfgIdxWidth = 1;
  localparam int unsigned CfgDatWidth = 8;

  // One shift per input bit.
  localparam int unsigned ConvSteps   = NumWidth;
  localparam int unsigned ConvCntW    = $clog2(ConvSteps + 1);

  // Byte positions inside one frame.
  localparam int unsigned RunLen      = 19;
  localparam int unsigned PosW        = $clog2(RunLen);
  localparam logic [PosW-1:0] PosBright  = PosW'(0);
  localparam logic [PosW-1:0] PosAutoInc = PosW'(1);
  localparam logic [PosW-1:0] PosAddr    = PosW'(2);
  localparam logic [PosW-1:0] PosData0   = PosW'(3);
  localparam logic [PosW-1:0] PosLast    = PosW'(RunLen - 1);

  // Controller command bytes.
  localparam logic [ByteWidth-1:0] CmdBrightBase = 8'h88;
  localparam logic [ByteWidth-1:0] CmdAutoInc    = 8'h40;
  localparam logic [ByteWidth-1:0] CmdAddr0      = 8'hC0;
  localparam logic [ByteWidth-1:0] LedFirst      = 8'h80;
  localparam logic [ByteWidth-1:0] LedOff        = 8'h00;

  // Configuration register indexes.
  localparam logic [CfgIdxWidth-1:0] RegBrightness = 1'b0;
  localparam logic [CfgIdxWidth-1:0] RegBlankMask  = 1'b1;

  localparam logic [BrightWidth-1:0] BrightReset = 3'd2;
  localparam logic [NumPlaces-1:0]   MaskReset   = 8'h00;

  typedef enum logic [1:0] {
    StIdle,
    StConv,
    StSend
  } dsf_state_e;

  typedef struct packed {
    logic [BrightWidth-1:0] brightness;
    logic [NumPlaces-1:0]   blank_mask;
  } dsf_cfg_t;

  typedef struct packed {
    logic start;
  } dsf_start_t;

  typedef struct packed {
    logic busy;
  } dsf_stat_t;

  // Common-cathode segment patterns for the decimal digits.
  function automatic logic [ByteWidth-1:0] seg_pattern(input logic [DigitWidth-1:0] digit);
    logic [ByteWidth-1:0] pat;
    unique case (digit)
      4'd0:    pat = 8'h3F;
      4'd1:    pat = 8'h06;
      4'd2:    pat = 8'h5B;
      4'd3:    pat = 8'h4F;
      4'd4:    pat = 8'h66;
      4'd5:    pat = 8'h6D;
      4'd6:    pat = 8'h7D;
      4'd7:    pat = 8'h07;
      4'd8:    pat = 8'h7F;
      4'd9:    pat = 8'h6F;
      default: pat = 8'h00;
    endcase
    return pat;
  endfunction

endpackage

`default_nettype wire

// File: sv/decimal_seven_segment_frame_encoder_core.sv
// Channel | Direction | Handshake                  | Payload
// in      | input     | in_valid_i / in_stall_o    | number_i[26:0]
// out     | output    | out_valid_o / out_stall_i  | out_byte_o[7:0], strobe_end_o, last_o
// cfg     | input     | cfg_we_i (no wait)         | cfg_idx_i[0], cfg_data_i[7:0]
//
// Each accepted number produces a frame of 19 bytes. An item is accepted,
// shifted through the binary to decimal shift register (one input bit per
// cycle), handed as digits to the frame sequencer, and then sent out as
// the frame's bytes. Stalls on the output hold the current byte. The block
// takes one item at a time, so in_stall_o stays high from acceptance until
// the last byte is taken.
// Reset brings the configuration to brightness 2 and no blanking.

`default_nettype none

module decimal_seven_segment_frame_encoder_core (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // Input channel.
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic [dsf_pkg::NumWidth-1:0]       number_i,
  // Output channel.
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic [dsf_pkg::ByteWidth-1:0]           out_byte_o,
  output logic                                    strobe_end_o,
  output logic                                    last_o,
  // Configuration write port.
  input  wire logic                               cfg_we_i,
  input  wire logic [dsf_pkg::CfgIdxWidth-1:0]    cfg_idx_i,
  input  wire logic [dsf_pkg::CfgDatWidth-1:0]    cfg_data_i
);
  import dsf_pkg::*;

  dsf_state_e state_q, state_d;
  dsf_cfg_t   cfg_q;
  dsf_start_t conv_ctrl, seq_ctrl;
  dsf_stat_t  conv_stat, seq_stat;
  logic [BcdWidth-1:0] bcd;
  logic       in_accept;
  logic       out_done;

  // The two configuration registers. The user must write them only while idle; the block itself does not enforce it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.brightness <= BrightReset;
      cfg_q.blank_mask <= MaskReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegBrightness: cfg_q.brightness <= cfg_data_i[BrightWidth-1:0];
        RegBlankMask:  cfg_q.blank_mask <= cfg_data_i[NumPlaces-1:0];
        default:       cfg_q            <= cfg_q;
      endcase
    end
  end

  assign in_accept = in_valid_i && !in_stall_o;
  assign out_done  = out_valid_o && !out_stall_i && last_o;

  // Next-state logic: idle, converting, then sending the frame.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (in_accept) state_d = StConv;
      end
      StConv: begin
        if (!conv_stat.busy) state_d = StSend;
      end
      StSend: begin
        if (out_done) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // Output logic: the input stall and the start pulses for the converter and the frame sequencer.
  always_comb begin
    in_stall_o      = 1'b1;
    conv_ctrl.start = 1'b0;
    seq_ctrl.start  = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_stall_o      = 1'b0;
        conv_ctrl.start = in_valid_i;
      end
      StConv: begin
        seq_ctrl.start = !conv_stat.busy;
      end
      StSend: begin
        seq_ctrl.start = 1'b0;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  dsf_bcd_conv u_conv (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (conv_ctrl),
    .number_i (number_i),
    .stat_o   (conv_stat),
    .bcd_o    (bcd)
  );

  // The digits stay in the converter's register while the frame goes out.
  dsf_frame_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (seq_ctrl),
    .cfg_i        (cfg_q),
    .bcd_i        (bcd),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .out_byte_o   (out_byte_o),
    .strobe_end_o (strobe_end_o),
    .last_o       (last_o),
    .stat_o       (seq_stat)
  );

  // The sequencer is busy exactly while the frame is being sent.
  logic unused_seq_busy;
  assign unused_seq_busy = seq_stat.busy;

endmodule

`default_nettype wire

// File: sv/dsf_bcd_conv.sv
`default_nettype none

// Shift-and-add-3 binary to BCD converter, one input bit per cycle.
module dsf_bcd_conv (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire dsf_pkg::dsf_start_t           ctrl_i,
  input  wire logic [dsf_pkg::NumWidth-1:0]  number_i,
  output dsf_pkg::dsf_stat_t                 stat_o,
  output logic [dsf_pkg::BcdWidth-1:0]       bcd_o
);
  import dsf_pkg::*;

  logic [NumWidth-1:0] bin_q, bin_d;
  logic [BcdWidth-1:0] bcd_q, bcd_d;
  logic [ConvCntW-1:0] cnt_q, cnt_d;
  logic [BcdWidth-1:0] adj;

  // Each digit lane is corrected on its own before the shift.
  always_comb begin
    for (int i = 0; i < NumPlaces; i++) begin
      if (bcd_q[i*DigitWidth +: DigitWidth] >= DigitWidth'(5)) begin
        adj[i*DigitWidth +: DigitWidth] = bcd_q[i*DigitWidth +: DigitWidth] + DigitWidth'(3);
      end else begin
        adj[i*DigitWidth +: DigitWidth] = bcd_q[i*DigitWidth +: DigitWidth];
      end
    end
  end

  // The carry out of the top digit is dropped, which keeps the value modulo 10^8.
  always_comb begin
    bin_d = bin_q;
    bcd_d = bcd_q;
    cnt_d = cnt_q;
    if (ctrl_i.start) begin
      bin_d = number_i;
      bcd_d = '0;
      cnt_d = ConvCntW'(ConvSteps);
    end else if (cnt_q != '0) begin
      bin_d = {bin_q[NumWidth-2:0], 1'b0};
      bcd_d = {adj[BcdWidth-2:0], bin_q[NumWidth-1]};
      cnt_d = cnt_q - ConvCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
  end

  assign stat_o.busy = (cnt_q != '0);
  assign bcd_o       = bcd_q;

endmodule

`default_nettype wire

// File: sv/dsf_frame_seq.sv
`default_nettype none

// Walks through the nineteen bytes of a frame, one per accepted result.
module dsf_frame_seq (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire dsf_pkg::dsf_start_t           ctrl_i,
  input  wire dsf_pkg::dsf_cfg_t             cfg_i,
  input  wire logic [dsf_pkg::BcdWidth-1:0]  bcd_i,
  input  wire logic                          out_stall_i,
  output logic                               out_valid_o,
  output logic [dsf_pkg::ByteWidth-1:0]      out_byte_o,
  output logic                               strobe_end_o,
  output logic                               last_o,
  output dsf_pkg::dsf_stat_t                 stat_o
);
  import dsf_pkg::*;

  logic            valid_q, valid_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic [3:0]      rel;
  logic [2:0]      seg_k;
  logic [ByteWidth-1:0] data_byte;
  logic            accept;

  assign accept = valid_q && !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    pos_d   = pos_q;
    if (ctrl_i.start) begin
      valid_d = 1'b1;
      pos_d   = '0;
    end else if (accept) begin
      if (pos_q == PosLast) begin
        valid_d = 1'b0;
      end else begin
        pos_d = pos_q + PosW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      pos_q   <= '0;
    end else begin
      valid_q <= valid_d;
      pos_q   <= pos_d;
    end
  end

  // After the address byte, even offsets carry segment rows and odd ones LED bytes.
  assign rel   = 4'(pos_q - PosData0);
  assign seg_k = rel[3:1];

  // Segment row k collects bit k of every place's pattern.
  always_comb begin
    logic [ByteWidth-1:0] pat;
    for (int i = 0; i < NumPlaces; i++) begin
      pat = seg_pattern(bcd_i[i*DigitWidth +: DigitWidth]);
      data_byte[i] = pat[seg_k] && !cfg_i.blank_mask[i];
    end
  end

  always_comb begin
    priority if (pos_q == PosBright) begin
      out_byte_o = CmdBrightBase + ByteWidth'(cfg_i.brightness);
    end else if (pos_q == PosAutoInc) begin
      out_byte_o = CmdAutoInc;
    end else if (pos_q == PosAddr) begin
      out_byte_o = CmdAddr0;
    end else if (!rel[0]) begin
      out_byte_o = data_byte;
    end else if (seg_k == 3'd0) begin
      out_byte_o = LedFirst;
    end else begin
      out_byte_o = LedOff;
    end
  end

  assign out_valid_o  = valid_q;
  assign last_o       = (pos_q == PosLast);
  assign strobe_end_o = (pos_q == PosBright) || (pos_q == PosAutoInc) || (pos_q == PosLast);
  assign stat_o.busy  = valid_q;

endmodule

`default_nettype wire

// File: sv/dsf_checker.sv
`default_nettype none

module dsf_checker (
  input wire logic                              clk_i,
  input wire logic                              rst_ni,
  input wire logic                              in_valid_i,
  input wire logic                              in_stall_o,
  input wire logic                              out_valid_o,
  input wire logic                              out_stall_i,
  input wire logic [dsf_pkg::ByteWidth-1:0]     out_byte_o,
  input wire logic                              strobe_end_o,
  input wire logic                              last_o
);

  // The final byte of a frame always ends a transfer.
  a_last_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_o |-> strobe_end_o)
    else $error("last byte without strobe_end");

  // Only one item is in flight: no input is taken while a frame goes out.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input open while a frame is being sent");

  // After an item is taken, the input closes and conversion precedes output.
  a_accept_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o && !out_valid_o)
    else $error("input not closed after acceptance");

  // A stalled byte stays on the port unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_byte_o) && $stable(last_o))
    else $error("stalled output changed");

endmodule

bind decimal_seven_segment_frame_encoder_core dsf_checker u_dsf_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .out_byte_o   (out_byte_o),
  .strobe_end_o (strobe_end_o),
  .last_o       (last_o)
);

`default_nettype wire

// File: test/decimal_seven_segment_frame_encoder_core_tb.sv
module decimal_seven_segment_frame_encoder_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dsf_pkg::*;

  // One byte of a display frame as it leaves the output channel.
  typedef struct packed {
    logic [ByteWidth-1:0] octet;
    logic                 strobe;
    logic                 last_flag;
  } frame_byte_t;

  typedef frame_byte_t [RunLen-1:0] frame_t;

  // Plane k holds segment k of every place, bit i taken from place i.
  typedef logic [7:0][NumPlaces-1:0] planes_t;

  typedef enum logic {
    RowNumber,
    RowRegWrite
  } row_kind_e;

  typedef struct packed {
    row_kind_e              kind;
    logic [CfgIdxWidth-1:0] reg_idx;
    logic [CfgDatWidth-1:0] reg_data;
    logic [NumWidth-1:0]    number;
    logic                   typed;
    planes_t                planes;
  } stim_row_t;

  typedef enum int unsigned {
    StallNone,
    StallLight,
    StallHeavy,
    StallPeriodic,
    StallRuns
  } stall_mode_e;

  // Segment patterns for the digits 0..9, entry d at index d.
  localparam logic [9:0][7:0] GlyphLut = {
    8'h6F, 8'h7F, 8'h07, 8'h7D, 8'h6D, 8'h66, 8'h4F, 8'h5B, 8'h06, 8'h3F
  };

  localparam int unsigned DirCount      = 20;
  localparam int unsigned RandPhases    = 6;
  localparam int unsigned ItemsPerPhase = 60;
  // Idle cycles waited after the last byte before the registers change.
  localparam int unsigned CfgSettle     = 4;
  localparam int unsigned EndDrain      = 60;
  localparam int unsigned WatchdogLimit = 1500;
  localparam int unsigned ReportLimit   = 10;

  logic                   clk_i       = 1'b0;
  logic                   rst_ni      = 1'b0;
  logic                   in_valid_i  = 1'b0;
  logic                   in_stall_o;
  logic [NumWidth-1:0]    number_i    = '0;
  logic                   out_valid_o;
  logic                   out_stall_i = 1'b0;
  logic [ByteWidth-1:0]   out_byte_o;
  logic                   strobe_end_o;
  logic                   last_o;
  logic                   cfg_we_i    = 1'b0;
  logic [CfgIdxWidth-1:0] cfg_idx_i   = '0;
  logic [CfgDatWidth-1:0] cfg_data_i  = '0;

  // Expected frame of the number currently offered on the input channel.
  // It is driven together with number_i, so the monitor picks up the frame
  // that belongs to the item accepted at that edge.
  frame_t pend_frame = '0;

  frame_byte_t frame_bytes_q[$];

  logic [BrightWidth-1:0] level_shadow;
  logic [NumPlaces-1:0]   mask_shadow;

  int unsigned errors         = 0;
  int unsigned numbers_taken  = 0;
  int unsigned bytes_checked  = 0;
  int unsigned reg_writes     = 0;
  int unsigned idle_cycles    = 0;

  stall_mode_e stall_mode = StallNone;
  int unsigned stall_tick = 0;
  int unsigned stall_run  = 0;
  logic        stall_hold = 1'b0;

  decimal_seven_segment_frame_encoder_core DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .number_i     (number_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_byte_o   (out_byte_o),
    .strobe_end_o (strobe_end_o),
    .last_o       (last_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Splits the number into its eight low decimal places, looks up each
  // glyph (blanked places stay dark) and transposes the glyphs into planes.
  // Anything above eight digits falls away because only eight places exist.
  function automatic planes_t segment_planes(input logic [NumWidth-1:0] num,
                                             input logic [NumPlaces-1:0] mask);
    int unsigned rest;
    logic [7:0]  glyph;
    planes_t     p;
    rest = 32'(num);
    p    = '0;
    for (int i = 0; i < NumPlaces; i++) begin
      glyph = mask[i] ? 8'h00 : GlyphLut[4'(rest % 10)];
      rest  = rest / 10;
      for (int k = 0; k < 8; k++) begin
        p[k][i] = glyph[k];
      end
    end
    return p;
  endfunction

  // Lays out the 19 bytes of one frame: brightness command and auto-increment
  // command each end their own transfer, then the address and the sixteen
  // data and LED bytes form the third transfer.
  function automatic frame_t frame_of(input planes_t planes,
                                      input logic [BrightWidth-1:0] level);
    frame_t f;
    f[0] = '{CmdBrightBase + ByteWidth'(level), 1'b1, 1'b0};
    f[1] = '{CmdAutoInc, 1'b1, 1'b0};
    f[2] = '{CmdAddr0, 1'b0, 1'b0};
    for (int k = 0; k < 8; k++) begin
      f[3 + 2 * k] = '{planes[k], 1'b0, 1'b0};
      f[4 + 2 * k] = '{(k == 0) ? LedFirst : LedOff, 1'(k == 7), 1'(k == 7)};
    end
    return f;
  endfunction

  // Directed rows. Planes are typed in only where the digits are all alike
  // or the whole display is dark; the rest go through the predictor.
  function automatic stim_row_t directed_row(input int unsigned n);
    stim_row_t r;
    r = '0;
    case (n)
      0:  r = '{RowNumber, RegBrightness, 8'h00, 27'd0, 1'b1, 64'h0000_FFFF_FFFF_FFFF};
      1:  r = '{RowNumber, RegBrightness, 8'h00, 27'd99999999, 1'b1,
                64'h00FF_FF00_FFFF_FFFF};
      2:  r = '{RowNumber, RegBrightness, 8'h00, 27'd88888888, 1'b1,
                64'h00FF_FFFF_FFFF_FFFF};
      3:  r = '{RowNumber, RegBrightness, 8'h00, 27'd11111111, 1'b1,
                64'h0000_0000_00FF_FF00};
      4:  r = '{RowNumber, RegBrightness, 8'h00, 27'd12345678, 1'b0, 64'h0};
      5:  r = '{RowNumber, RegBrightness, 8'h00, 27'd90817263, 1'b0, 64'h0};
      // Just past eight digits: the value wraps and shows as all zeros.
      6:  r = '{RowNumber, RegBrightness, 8'h00, 27'd100000000, 1'b1,
                64'h0000_FFFF_FFFF_FFFF};
      7:  r = '{RowNumber, RegBrightness, 8'h00, 27'h7FF_FFFF, 1'b0, 64'h0};
      // Upper data bits must be dropped, leaving brightness 7.
      8:  r = '{RowRegWrite, RegBrightness, 8'hFF, 27'd0, 1'b0, 64'h0};
      9:  r = '{RowRegWrite, RegBlankMask, 8'hFF, 27'd0, 1'b0, 64'h0};
      10: r = '{RowNumber, RegBrightness, 8'h00, 27'd88888888, 1'b1, 64'h0};
      11: r = '{RowRegWrite, RegBlankMask, 8'h20, 27'd0, 1'b0, 64'h0};
      12: r = '{RowNumber, RegBrightness, 8'h00, 27'd88888888, 1'b1,
                64'h00DF_DFDF_DFDF_DFDF};
      13: r = '{RowNumber, RegBrightness, 8'h00, 27'd40506070, 1'b0, 64'h0};
      // Only bit 3 is set, which lies outside the register: level 0.
      14: r = '{RowRegWrite, RegBrightness, 8'h08, 27'd0, 1'b0, 64'h0};
      15: r = '{RowRegWrite, RegBlankMask, 8'h00, 27'd0, 1'b0, 64'h0};
      16: r = '{RowNumber, RegBrightness, 8'h00, 27'd99999999, 1'b1,
                64'h00FF_FF00_FFFF_FFFF};
      17: r = '{RowRegWrite, RegBlankMask, 8'h81, 27'd0, 1'b0, 64'h0};
      18: r = '{RowNumber, RegBrightness, 8'h00, 27'd55555555, 1'b0, 64'h0};
      default: r = '{RowNumber, RegBrightness, 8'h00, 27'd1, 1'b0, 64'h0};
    endcase
    return r;
  endfunction

  // Mostly in-range values, with full 27-bit noise, values around the
  // eight-digit wrap and the top of the field, nines-heavy digit strings
  // and short numbers that leave long runs of leading zeros.
  function automatic logic [NumWidth-1:0] random_number();
    int unsigned v;
    v = 0;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: v = $urandom_range(0, 99999999);
      5, 6:          v = $urandom() & 32'h07FF_FFFF;
      7: begin
        if ($urandom_range(0, 1) == 1) begin
          v = $urandom_range(99999990, 100000009);
        end else begin
          v = $urandom_range(134217700, 134217727);
        end
      end
      8: begin
        for (int i = 0; i < NumPlaces; i++) begin
          v = v * 10 + (($urandom_range(0, 2) == 0) ? 9 : $urandom_range(0, 9));
        end
      end
      default: v = $urandom_range(0, 999);
    endcase
    return NumWidth'(v);
  endfunction

  // Offers one number and returns at the edge where it is taken. Valid is
  // left high so that a following item can go out without a gap.
  task automatic offer_number(input logic [NumWidth-1:0] num, input frame_t f);
    in_valid_i <= 1'b1;
    number_i   <= num;
    pend_frame <= f;
    do begin
      @(posedge clk_i);
    end while (in_stall_o);
  endtask

  task automatic sender_gap(input int unsigned cycles);
    in_valid_i <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // Registers change only once every byte already predicted has come out,
  // so each frame is checked against the setting it was taken under. The
  // wait starts at the falling clock edge, after the monitor has queued the frame
  // of an item taken at the current edge.
  task automatic write_reg(input logic [CfgIdxWidth-1:0] idx,
                           input logic [CfgDatWidth-1:0] data);
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    wait (frame_bytes_q.size() == 0);
    repeat (CfgSettle) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == RegBrightness) begin
      level_shadow = data[BrightWidth-1:0];
    end else begin
      mask_shadow = data[NumPlaces-1:0];
    end
    reg_writes++;
  endtask

  // The output side stalls in a mode that is redrawn at random as stall_tick runs: never,
  // lightly, heavily, on a fixed period, or in long random runs.
  always @(posedge clk_i) begin
    stall_tick++;
    if (stall_tick % 256 == 0) begin
      stall_mode = stall_mode_e'($urandom_range(0, 4));
    end
    case (stall_mode)
      StallNone:     out_stall_i <= 1'b0;
      StallLight:    out_stall_i <= ($urandom_range(0, 3) == 0);
      StallHeavy:    out_stall_i <= ($urandom_range(0, 3) != 0);
      StallPeriodic: out_stall_i <= ((stall_tick % 7) < 3);
      default: begin
        if (stall_run == 0) begin
          stall_hold = !stall_hold;
          stall_run  = $urandom_range(1, 24);
        end
        stall_run--;
        out_stall_i <= stall_hold;
      end
    endcase
  end

  // Monitor: queues the frame of every accepted number, checks every byte
  // taken from the output, and ends the run if nothing moves for too long.
  always @(posedge clk_i) begin
    frame_byte_t want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        for (int j = 0; j < RunLen; j++) begin
          frame_bytes_q.push_back(pend_frame[j]);
        end
        numbers_taken++;
      end
      if (out_valid_o && !out_stall_i) begin
        if (frame_bytes_q.size() == 0) begin
          if (errors < ReportLimit) begin
            $display("Unexpected byte %02h strobe %b last %b with no frame pending",
                     out_byte_o, strobe_end_o, last_o);
          end
          errors++;
        end else begin
          want = frame_bytes_q.pop_front();
          if (want.octet !== out_byte_o || want.strobe !== strobe_end_o ||
              want.last_flag !== last_o) begin
            if (errors < ReportLimit) begin
              $display("Byte %0d: expected %02h strobe %b last %b, got %02h strobe %b last %b",
                       bytes_checked % RunLen, want.octet, want.strobe, want.last_flag,
                       out_byte_o, strobe_end_o, last_o);
            end
            errors++;
          end
          bytes_checked++;
        end
      end
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WatchdogLimit) begin
        $display("Timeout: no item moved for %0d cycles", WatchdogLimit);
        $display("decimal_seven_segment_frame_encoder_core verification failed");
        $finish;
      end
    end
  end

  initial begin
    stim_row_t             row;
    planes_t               planes;
    logic [NumWidth-1:0]   num;
    logic [BrightWidth-1:0] level;
    logic [NumPlaces-1:0]  mask;
    int unsigned           burst_left;

    level_shadow = BrightReset;
    mask_shadow  = MaskReset;
    burst_left   = 0;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: the first rows run under the reset configuration.
    for (int n = 0; n < DirCount; n++) begin
      row = directed_row(n);
      if (row.kind == RowRegWrite) begin
        write_reg(row.reg_idx, row.reg_data);
      end else begin
        planes = row.typed ? row.planes : segment_planes(row.number, mask_shadow);
        offer_number(row.number, frame_of(planes, level_shadow));
      end
    end

    // Random part: each phase picks a new setting, the first phases the
    // extreme ones, then sends numbers in bursts with random gaps.
    for (int p = 0; p < RandPhases; p++) begin
      case (p)
        0:       level = 3'd7;
        1:       level = 3'd0;
        default: level = BrightWidth'($urandom_range(0, 7));
      endcase
      case (p)
        1:       mask = 8'h00;
        2:       mask = 8'hFF;
        3:       mask = 8'h20;
        default: mask = NumPlaces'($urandom());
      endcase
      write_reg(RegBrightness, {5'($urandom()), level});
      write_reg(RegBlankMask, mask);
      for (int i = 0; i < ItemsPerPhase; i++) begin
        if (burst_left == 0) begin
          sender_gap($urandom_range(1, 70));
          burst_left = $urandom_range(1, 10);
        end
        burst_left--;
        num = random_number();
        offer_number(num, frame_of(segment_planes(num, mask_shadow), level_shadow));
      end
    end

    in_valid_i <= 1'b0;
    @(negedge clk_i);
    wait (frame_bytes_q.size() == 0);
    repeat (EndDrain) @(posedge clk_i);

    $display("Ran %0d numbers through %0d register writes, %0d frame bytes compared.",
             numbers_taken, reg_writes, bytes_checked);
    $display("Covered wrap past eight digits, all blanking extremes and brightness 0 to 7.");
    if (errors == 0 && frame_bytes_q.size() == 0) begin
      $display("decimal_seven_segment_frame_encoder_core verification clean");
    end else begin
      $display("%0d mismatches, %0d bytes still expected", errors, frame_bytes_q.size());
      $display("decimal_seven_segment_frame_encoder_core verification failed");
    end
    $finish;
  end

endmodule
